### rtl/core/dbsb_pkg.sv
package dbsb_pkg;

   // bank geometry
   localparam int CAPACITY    = 1024;
   localparam int SLOT_WIDTH  = $clog2(CAPACITY);
   localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);
   localparam int ADDR_WIDTH  = SLOT_WIDTH + 1;

   // word fields
   localparam int COORD_WIDTH = 32;
   localparam int RAND_WIDTH  = 31;
   localparam int STEP_WIDTH  = $clog2(RAND_WIDTH);

   // request codes
   localparam logic [1:0] REQ_ADD    = 2'd0;
   localparam logic [1:0] REQ_SAMPLE = 2'd1;
   localparam logic [1:0] REQ_BATCH  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_ACCESS,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic signed [COORD_WIDTH-1:0] z;
   } site_type;

endpackage

### rtl/core/double_buffered_site_bank.sv
// Double-buffered site bank: two banks of 3-D Q16.16 sites used ping-pong.
// Request channel (req_valid / req_stall): req_type 0 adds a site to the new
// bank, 1 samples a site from the old bank, 2 swaps banks and clears counts.
// Response channel (rsp_valid / rsp_stall): one word per request with the
// sampled site, the slot touched and an empty-bank status bit.
// csr_write_enable / csr_write_data set the per-batch slot limit; write only
// while the block is idle.
// Sequencing: a new batch, an empty sample or an unknown code goes from
// acceptance straight to the finish state; an in-order add or sample
// passes through one bank memory access first; an add to a full bank or a
// random sample first runs the one-bit-per-cycle modulo unit (31 steps),
// then the access. The finish state hands the word to the output register.
// One request is in flight at a time; req_stall is high from acceptance
// until the response is handed to the output register.
// A stalled response holds in its register; the next request may be
// accepted and worked on meanwhile, and waits to finish until it frees.
// Reset (synchronous, active high) empties both banks logically, clears all
// counts, selects bank A as old and sets the limit to the full capacity.
module double_buffered_site_bank (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_type,
   input  logic signed [dbsb_pkg::COORD_WIDTH-1:0] req_pos_x,
   input  logic signed [dbsb_pkg::COORD_WIDTH-1:0] req_pos_y,
   input  logic signed [dbsb_pkg::COORD_WIDTH-1:0] req_pos_z,
   input  logic [dbsb_pkg::RAND_WIDTH-1:0]      req_rand_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [dbsb_pkg::COORD_WIDTH-1:0] rsp_out_x,
   output logic signed [dbsb_pkg::COORD_WIDTH-1:0] rsp_out_y,
   output logic signed [dbsb_pkg::COORD_WIDTH-1:0] rsp_out_z,
   output logic [dbsb_pkg::SLOT_WIDTH-1:0]      rsp_slot_index,
   output logic                                 rsp_status,
   input  logic                                 csr_write_enable,
   input  logic [dbsb_pkg::COUNT_WIDTH-1:0]     csr_write_data
);

   // sequencer
   dbsb_pkg::state_type state_ff, state_in;
   logic [1:0] op_ff, op_in;
   logic [dbsb_pkg::SLOT_WIDTH-1:0] slot_ff, slot_in;
   logic status_ff, status_in;
   dbsb_pkg::site_type site_ff, site_in;

   // modulo unit
   logic [dbsb_pkg::RAND_WIDTH-1:0] div_value_ff, div_value_in;
   logic [dbsb_pkg::COUNT_WIDTH-1:0] rem_ff, rem_in;
   logic [dbsb_pkg::COUNT_WIDTH-1:0] divisor_ff, divisor_in;
   logic [dbsb_pkg::STEP_WIDTH-1:0] step_ff, step_in;
   logic [dbsb_pkg::COUNT_WIDTH:0] div_trial;
   logic [dbsb_pkg::COUNT_WIDTH:0] div_diff;

   // bank bookkeeping
   logic old_sel_ff, old_sel_in;
   logic [dbsb_pkg::COUNT_WIDTH-1:0] fill_count_ff, fill_count_in;
   logic [dbsb_pkg::COUNT_WIDTH-1:0] old_count_ff, old_count_in;
   logic [dbsb_pkg::COUNT_WIDTH-1:0] sampled_count_ff, sampled_count_in;
   logic [dbsb_pkg::COUNT_WIDTH-1:0] sites_limit_ff;
   logic [dbsb_pkg::COUNT_WIDTH-1:0] limit;

   // bank memory
   dbsb_pkg::site_type bank_mem [2*dbsb_pkg::CAPACITY];
   dbsb_pkg::site_type rd_data_ff;
   logic mem_we;
   logic mem_re;
   logic [dbsb_pkg::ADDR_WIDTH-1:0] mem_addr;

   // response register
   logic rsp_valid_ff;
   logic rsp_load;
   dbsb_pkg::site_type rsp_site_ff, rsp_site_in;
   logic [dbsb_pkg::SLOT_WIDTH-1:0] rsp_slot_ff, rsp_slot_in;
   logic rsp_status_ff;

   // limit clamped to 1..CAPACITY
   always_comb begin
      if (sites_limit_ff == '0) begin
         limit = dbsb_pkg::COUNT_WIDTH'(1);
      end else if (sites_limit_ff > dbsb_pkg::COUNT_WIDTH'(dbsb_pkg::CAPACITY)) begin
         limit = dbsb_pkg::COUNT_WIDTH'(dbsb_pkg::CAPACITY);
      end else begin
         limit = sites_limit_ff;
      end
   end

   // one restoring step: shift in the next dividend bit, subtract if it fits
   assign div_trial = {rem_ff, div_value_ff[dbsb_pkg::RAND_WIDTH-1]};
   assign div_diff  = div_trial - {1'b0, divisor_ff};

   // next state and datapath control
   always_comb begin
      state_in         = state_ff;
      op_in            = op_ff;
      slot_in          = slot_ff;
      status_in        = status_ff;
      site_in          = site_ff;
      div_value_in     = div_value_ff;
      rem_in           = rem_ff;
      divisor_in       = divisor_ff;
      step_in          = step_ff;
      old_sel_in       = old_sel_ff;
      fill_count_in    = fill_count_ff;
      old_count_in     = old_count_ff;
      sampled_count_in = sampled_count_ff;
      mem_we           = 1'b0;
      mem_re           = 1'b0;
      mem_addr         = {old_sel_ff, slot_ff};
      rsp_load         = 1'b0;

      unique case (state_ff)
         dbsb_pkg::ST_IDLE: begin
            if (req_valid) begin
               op_in        = req_type;
               site_in      = '{x: req_pos_x, y: req_pos_y, z: req_pos_z};
               div_value_in = req_rand_value;
               rem_in       = '0;
               step_in      = '0;
               slot_in      = '0;
               status_in    = 1'b0;
               state_in     = dbsb_pkg::ST_FINISH;
               unique case (req_type)
                  dbsb_pkg::REQ_ADD: begin
                     if (fill_count_ff < limit) begin
                        slot_in       = fill_count_ff[dbsb_pkg::SLOT_WIDTH-1:0];
                        fill_count_in = fill_count_ff + 1'b1;
                        state_in      = dbsb_pkg::ST_ACCESS;
                     end else begin
                        divisor_in = limit;
                        state_in   = dbsb_pkg::ST_DIVIDE;
                     end
                  end
                  dbsb_pkg::REQ_SAMPLE: begin
                     if (old_count_ff == '0) begin
                        status_in = 1'b1;
                     end else begin
                        if (sampled_count_ff < old_count_ff && sampled_count_ff < limit) begin
                           slot_in  = sampled_count_ff[dbsb_pkg::SLOT_WIDTH-1:0];
                           state_in = dbsb_pkg::ST_ACCESS;
                        end else begin
                           divisor_in = old_count_ff;
                           state_in   = dbsb_pkg::ST_DIVIDE;
                        end
                        if (sampled_count_ff < old_count_ff) begin
                           sampled_count_in = sampled_count_ff + 1'b1;
                        end
                     end
                  end
                  dbsb_pkg::REQ_BATCH: begin
                     old_sel_in       = ~old_sel_ff;
                     old_count_in     = fill_count_ff;
                     fill_count_in    = '0;
                     sampled_count_in = '0;
                  end
                  default: begin
                     // unknown code: all-zero response, bank state unchanged
                  end
               endcase
            end
         end
         dbsb_pkg::ST_DIVIDE: begin
            if (!div_diff[dbsb_pkg::COUNT_WIDTH]) begin
               rem_in = div_diff[dbsb_pkg::COUNT_WIDTH-1:0];
            end else begin
               rem_in = div_trial[dbsb_pkg::COUNT_WIDTH-1:0];
            end
            div_value_in = {div_value_ff[dbsb_pkg::RAND_WIDTH-2:0], 1'b0};
            step_in      = step_ff + 1'b1;
            if (step_ff == dbsb_pkg::STEP_WIDTH'(dbsb_pkg::RAND_WIDTH - 1)) begin
               // remainder is below the divisor, so it fits a slot index
               slot_in  = rem_in[dbsb_pkg::SLOT_WIDTH-1:0];
               state_in = dbsb_pkg::ST_ACCESS;
            end
         end
         dbsb_pkg::ST_ACCESS: begin
            if (op_ff == dbsb_pkg::REQ_ADD) begin
               mem_addr = {~old_sel_ff, slot_ff};
               mem_we   = 1'b1;
            end else begin
               mem_addr = {old_sel_ff, slot_ff};
               mem_re   = 1'b1;
            end
            state_in = dbsb_pkg::ST_FINISH;
         end
         dbsb_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = dbsb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dbsb_pkg::ST_IDLE;
         end
      endcase
   end

   // response word contents
   always_comb begin
      rsp_site_in = '0;
      rsp_slot_in = '0;
      if (!status_ff) begin
         if (op_ff == dbsb_pkg::REQ_SAMPLE) begin
            rsp_site_in = rd_data_ff;
            rsp_slot_in = slot_ff;
         end else if (op_ff == dbsb_pkg::REQ_ADD) begin
            rsp_slot_in = slot_ff;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= dbsb_pkg::ST_IDLE;
         old_sel_ff       <= 1'b0;
         fill_count_ff    <= '0;
         old_count_ff     <= '0;
         sampled_count_ff <= '0;
         sites_limit_ff   <= dbsb_pkg::COUNT_WIDTH'(dbsb_pkg::CAPACITY);
      end else begin
         state_ff         <= state_in;
         old_sel_ff       <= old_sel_in;
         fill_count_ff    <= fill_count_in;
         old_count_ff     <= old_count_in;
         sampled_count_ff <= sampled_count_in;
         if (csr_write_enable) begin
            sites_limit_ff <= csr_write_data;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      slot_ff      <= slot_in;
      status_ff    <= status_in;
      site_ff      <= site_in;
      div_value_ff <= div_value_in;
      rem_ff       <= rem_in;
      divisor_ff   <= divisor_in;
      step_ff      <= step_in;
   end

   // bank memory: old bank at {old_sel, slot}, new bank at {~old_sel, slot}
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bank_mem[mem_addr] <= site_ff;
      end
      if (mem_re) begin
         rd_data_ff <= bank_mem[mem_addr];
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_site_ff   <= rsp_site_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_status_ff <= status_ff;
      end
   end

   assign req_stall      = (state_ff != dbsb_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_x      = rsp_site_ff.x;
   assign rsp_out_y      = rsp_site_ff.y;
   assign rsp_out_z      = rsp_site_ff.z;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_status     = rsp_status_ff;

`ifndef SYNTHESIS
   // partial remainder stays below the divisor while iterating
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dbsb_pkg::ST_DIVIDE) |-> (rem_ff < divisor_ff))
      else $error("modulo remainder not below divisor");

   // fill count never passes the bank capacity
   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= dbsb_pkg::COUNT_WIDTH'(dbsb_pkg::CAPACITY))
      else $error("fill count beyond capacity");

   // sequential sample count saturates at the old bank count
   a_sampled_bounded: assert property (@(posedge clock) disable iff (reset)
      sampled_count_ff <= old_count_ff)
      else $error("sampled count beyond old count");

   // a sample read stays inside the sites stored in the old bank
   a_sample_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dbsb_pkg::ST_ACCESS && op_ff == dbsb_pkg::REQ_SAMPLE)
      |-> ({1'b0, slot_ff} < old_count_ff))
      else $error("sample slot outside stored sites");

   // an in-flight word reaches the output register only after a free slot
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !rsp_load)
      else $error("response overwritten while stalled");
`endif

endmodule

### dv/testbench.sv
module testbench;

   localparam logic [1:0] REQ_IGNORED  = 2'd3;
   localparam logic       STATUS_OK    = 1'b0;
   localparam logic       STATUS_EMPTY = 1'b1;
   localparam int         QUIET_LIMIT  = 5000;
   localparam int         HOLD_CYCLES  = 400;
   localparam int         RANDOM_WORDS = 150;

   typedef struct packed {
      dbsb_pkg::site_type                    site;
      logic [dbsb_pkg::SLOT_WIDTH-1:0]       slot;
      logic                                  status;
   } bank_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                    req_valid = 1'b0;
   logic                                    req_stall;
   logic [1:0]                              req_type = dbsb_pkg::REQ_ADD;
   logic signed [dbsb_pkg::COORD_WIDTH-1:0] req_pos_x = '0;
   logic signed [dbsb_pkg::COORD_WIDTH-1:0] req_pos_y = '0;
   logic signed [dbsb_pkg::COORD_WIDTH-1:0] req_pos_z = '0;
   logic [dbsb_pkg::RAND_WIDTH-1:0]         req_rand_value = '0;
   logic                                    rsp_valid;
   logic                                    rsp_stall = 1'b0;
   logic signed [dbsb_pkg::COORD_WIDTH-1:0] rsp_out_x;
   logic signed [dbsb_pkg::COORD_WIDTH-1:0] rsp_out_y;
   logic signed [dbsb_pkg::COORD_WIDTH-1:0] rsp_out_z;
   logic [dbsb_pkg::SLOT_WIDTH-1:0]         rsp_slot_index;
   logic                                    rsp_status;
   logic                                    csr_write_enable = 1'b0;
   logic [dbsb_pkg::COUNT_WIDTH-1:0]        csr_write_data = '0;

   // predictor copy of the bank state
   dbsb_pkg::site_type               site_store [2][dbsb_pkg::CAPACITY];
   bit                               old_is_b;
   int unsigned                      new_fill;
   int unsigned                      old_fill;
   int unsigned                      ordered_reads;
   logic [dbsb_pkg::COUNT_WIDTH-1:0] slot_limit = dbsb_pkg::COUNT_WIDTH'(dbsb_pkg::CAPACITY);

   bank_reply_type expected_replies [$];
   int             error_count;

   // idling knobs, set per test
   int send_gap_pct;
   int stall_pct;
   int long_hold_cycles;
   int hold_left;
   int stall_run_left;
   int quiet_cycles;

   double_buffered_site_bank uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_rand_value   (req_rand_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_out_z        (rsp_out_z),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // limit as the block applies it: 0 acts as 1, above capacity clamps
   function automatic int unsigned active_limit();
      int unsigned lim;
      lim = int'(slot_limit);
      if (lim == 0) lim = 1;
      if (lim > dbsb_pkg::CAPACITY) lim = dbsb_pkg::CAPACITY;
      return lim;
   endfunction

   // expected reply for one accepted request; updates the predictor state
   function automatic bank_reply_type predict_reply(
         input logic [1:0] kind, input dbsb_pkg::site_type pos,
         input logic [dbsb_pkg::RAND_WIDTH-1:0] rnd);
      bank_reply_type rep;
      int unsigned lim;
      int unsigned slot;
      rep = '0;
      rep.status = STATUS_OK;
      lim = active_limit();
      case (kind)
         dbsb_pkg::REQ_ADD: begin
            // append while room is left, else replace a random slot
            if (new_fill < lim) begin
               slot = new_fill;
               new_fill++;
            end else begin
               slot = rnd % lim;
            end
            site_store[int'(!old_is_b)][slot] = pos;
            rep.slot = slot[dbsb_pkg::SLOT_WIDTH-1:0];
         end
         dbsb_pkg::REQ_SAMPLE: begin
            if (old_fill == 0) begin
               rep.status = STATUS_EMPTY;
            end else begin
               // in order first, then random over what the old bank holds
               if (ordered_reads < old_fill && ordered_reads < lim) slot = ordered_reads;
               else slot = rnd % old_fill;
               rep.site = site_store[int'(old_is_b)][slot];
               rep.slot = slot[dbsb_pkg::SLOT_WIDTH-1:0];
               if (ordered_reads < old_fill) ordered_reads++;
            end
         end
         dbsb_pkg::REQ_BATCH: begin
            old_is_b      = !old_is_b;
            old_fill      = new_fill;
            new_fill      = 0;
            ordered_reads = 0;
         end
         default: ;
      endcase
      return rep;
   endfunction

   function automatic int burst_length();
      return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(10, 40);
   endfunction

   function automatic logic [dbsb_pkg::COORD_WIDTH-1:0] random_coord();
      case ($urandom_range(0, 19))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   function automatic dbsb_pkg::site_type random_site();
      dbsb_pkg::site_type s;
      s.x = random_coord();
      s.y = random_coord();
      s.z = random_coord();
      return s;
   endfunction

   function automatic logic [dbsb_pkg::RAND_WIDTH-1:0] random_draw();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         2:       return dbsb_pkg::RAND_WIDTH'($urandom_range(0, 15));
         default: return dbsb_pkg::RAND_WIDTH'($urandom());
      endcase
   endfunction

   function automatic logic [1:0] random_kind();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return dbsb_pkg::REQ_ADD;
      if (pick < 90) return dbsb_pkg::REQ_SAMPLE;
      if (pick < 95) return dbsb_pkg::REQ_BATCH;
      return REQ_IGNORED;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endfunction

   // offer one word, hold it until accepted, then record what should come back
   task automatic send_request(input logic [1:0] kind, input dbsb_pkg::site_type pos,
                               input logic [dbsb_pkg::RAND_WIDTH-1:0] rnd);
      int gap;
      gap = ($urandom_range(0, 99) < send_gap_pct) ? burst_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_pos_x      <= pos.x;
      req_pos_y      <= pos.y;
      req_pos_z      <= pos.z;
      req_rand_value <= rnd;
      do @(posedge clock); while (req_stall);
      expected_replies.insert(expected_replies.size(), predict_reply(kind, pos, rnd));
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
   endtask

   // one limit write, issued only with nothing in flight
   task automatic set_limit(input logic [dbsb_pkg::COUNT_WIDTH-1:0] value);
      wait_until_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      slot_limit = value;
      @(posedge clock);
   endtask

   // empty bank, ignored code, coordinate extremes, small and clamped limits
   task automatic test_directed();
      dbsb_pkg::site_type lo, hi, mix, zero;
      lo   = {32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
      hi   = {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
      mix  = {32'h8000_0000, 32'hFFFF_FFFF, 32'h0001_0000};
      zero = '0;
      send_gap_pct = 25;
      stall_pct    = 25;
      send_request(dbsb_pkg::REQ_SAMPLE, zero, '0);
      send_request(REQ_IGNORED, hi, '1);
      set_limit(dbsb_pkg::COUNT_WIDTH'(3));
      send_request(dbsb_pkg::REQ_ADD, lo, '1);
      send_request(dbsb_pkg::REQ_ADD, hi, '0);
      send_request(dbsb_pkg::REQ_ADD, mix, dbsb_pkg::RAND_WIDTH'(5));
      // bank full: replaces slot draw mod limit
      send_request(dbsb_pkg::REQ_ADD, zero, '1);
      send_request(dbsb_pkg::REQ_BATCH, zero, '0);
      repeat (3) send_request(dbsb_pkg::REQ_SAMPLE, zero, '1);
      send_request(dbsb_pkg::REQ_SAMPLE, zero, '1);
      send_request(dbsb_pkg::REQ_SAMPLE, zero, '0);
      // nothing added since the swap, so the old bank is empty again
      send_request(dbsb_pkg::REQ_BATCH, hi, '1);
      send_request(dbsb_pkg::REQ_SAMPLE, hi, '1);
      set_limit('0);
      send_request(dbsb_pkg::REQ_ADD, hi, '0);
      send_request(dbsb_pkg::REQ_ADD, lo, '1);
      send_request(dbsb_pkg::REQ_BATCH, zero, '0);
      send_request(dbsb_pkg::REQ_SAMPLE, zero, '0);
      send_request(dbsb_pkg::REQ_SAMPLE, zero, '1);
      set_limit('1);
   endtask

   // whole bank filled, then in-order reads cut short and resumed by the limit
   task automatic test_full_capacity();
      int i;
      send_gap_pct = 10;
      stall_pct    = 10;
      set_limit('1);
      send_request(dbsb_pkg::REQ_BATCH, random_site(), random_draw());
      for (i = 0; i < dbsb_pkg::CAPACITY; i++)
         send_request(dbsb_pkg::REQ_ADD, random_site(), random_draw());
      send_request(dbsb_pkg::REQ_ADD, random_site(), '1);
      for (i = 0; i < 5; i++) send_request(dbsb_pkg::REQ_ADD, random_site(), random_draw());
      send_request(dbsb_pkg::REQ_BATCH, random_site(), random_draw());
      for (i = 0; i < 5; i++) send_request(dbsb_pkg::REQ_SAMPLE, random_site(), random_draw());
      set_limit(dbsb_pkg::COUNT_WIDTH'(8));
      send_request(dbsb_pkg::REQ_SAMPLE, random_site(), '1);
      for (i = 0; i < 5; i++) send_request(dbsb_pkg::REQ_SAMPLE, random_site(), random_draw());
      set_limit(dbsb_pkg::COUNT_WIDTH'(dbsb_pkg::CAPACITY));
      for (i = 0; i < 4; i++) send_request(dbsb_pkg::REQ_SAMPLE, random_site(), random_draw());
   endtask

   // receiver holds off while words keep coming, so the block stalls its input
   task automatic test_backpressure();
      int i;
      send_gap_pct     = 0;
      stall_pct        = 0;
      long_hold_cycles = HOLD_CYCLES;
      for (i = 0; i < 16; i++) send_request(random_kind(), random_site(), random_draw());
      wait_until_drained();
   endtask

   // phases of random traffic, each closed by a new batch
   task automatic test_random_traffic(input int unsigned target);
      int unsigned sent;
      int          phase_len;
      int          i;
      logic [1:0]  kind;
      sent = 0;
      while (sent < target) begin
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 9))
               0:       set_limit('0);
               1:       set_limit('1);
               2:       set_limit(dbsb_pkg::COUNT_WIDTH'(dbsb_pkg::CAPACITY));
               3:       set_limit(dbsb_pkg::COUNT_WIDTH'($urandom()));
               4, 5:    set_limit(dbsb_pkg::COUNT_WIDTH'($urandom_range(17, 64)));
               default: set_limit(dbsb_pkg::COUNT_WIDTH'($urandom_range(1, 16)));
            endcase
         end
         case ($urandom_range(0, 3))
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 20; stall_pct = 20; end
            2: begin send_gap_pct = 50; stall_pct = 10; end
            default: begin send_gap_pct = 10; stall_pct = 60; end
         endcase
         phase_len = $urandom_range(1, 40);
         for (i = 0; i < phase_len; i++) begin
            kind = random_kind();
            send_request(kind, random_site(), random_draw());
            if (kind != REQ_IGNORED) sent++;
         end
         send_request(dbsb_pkg::REQ_BATCH, random_site(), random_draw());
         sent++;
      end
   endtask

   // receiver side: random stall bursts, or one long hold when a test asks
   always @(posedge clock) begin
      if (long_hold_cycles != 0) begin
         hold_left        = long_hold_cycles;
         long_hold_cycles = 0;
      end
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (stall_run_left != 0) begin
         stall_run_left--;
      end else begin
         rsp_stall      <= ($urandom_range(0, 99) < stall_pct);
         stall_run_left = burst_length();
      end
   end

   // compare each accepted word with the oldest expectation
   always @(posedge clock) begin : check_replies
      bank_reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_replies.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual slot %0d status %0d",
                     $time, rsp_slot_index, rsp_status);
            error_count++;
         end else begin
            want = expected_replies.pop_front();
            check_field("out_x", want.site.x, rsp_out_x);
            check_field("out_y", want.site.y, rsp_out_y);
            check_field("out_z", want.site.z, rsp_out_z);
            check_field("slot_index", 32'(want.slot), 32'(rsp_slot_index));
            check_field("status", 32'(want.status), 32'(rsp_status));
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("double_buffered_site_bank regression: fail");
            $finish;
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_capacity();
      test_backpressure();
      test_random_traffic(RANDOM_WORDS);
      wait_until_drained();
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("double_buffered_site_bank regression: pass");
      end else begin
         $display("double_buffered_site_bank regression: fail");
      end
      $finish;
   end

endmodule
